// File: rtl/led_pattern_sequencer_core_macros.svh
// Assertion macros shared by the sequencer RTL.
`ifndef LED_PATTERN_SEQUENCER_CORE_MACROS_SVH
`define LED_PATTERN_SEQUENCER_CORE_MACROS_SVH

`ifndef SYNTH
// Same-cycle implication, disabled during reset
`define LPS_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("sequencer assertion failed");
// Next-cycle implication, disabled during reset
`define LPS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("sequencer assertion failed");
`else
`define LPS_ASSERT_NOW(lbl, clk, rst_n, ante, cons)
`define LPS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

// File: rtl/lps_pkg.sv
package lps_pkg;

  // Event codes
  localparam logic [1:0] OP_TICK = 2'd0;
  localparam logic [1:0] OP_UP   = 2'd1;
  localparam logic [1:0] OP_DOWN = 2'd2;
  localparam logic [1:0] OP_CHAR = 2'd3;

  // Configuration register indexes
  localparam logic [2:0] REG_THRESHOLD_FAST   = 3'd0;
  localparam logic [2:0] REG_THRESHOLD_MEDIUM = 3'd1;
  localparam logic [2:0] REG_RELOAD_SLOW      = 3'd2;
  localparam logic [2:0] REG_RELOAD_MEDIUM    = 3'd3;
  localparam logic [2:0] REG_RELOAD_FAST      = 3'd4;

  // Register reset values
  localparam logic [9:0]  THRESHOLD_FAST_RST   = 10'd600;
  localparam logic [9:0]  THRESHOLD_MEDIUM_RST = 10'd400;
  localparam logic [15:0] RELOAD_SLOW_RST      = 16'd62421;
  localparam logic [15:0] RELOAD_MEDIUM_RST    = 16'd59273;
  localparam logic [15:0] RELOAD_FAST_RST      = 16'd53008;

  // Speed levels
  localparam logic [1:0] LEVEL_SLOW   = 2'd0;
  localparam logic [1:0] LEVEL_MEDIUM = 2'd1;
  localparam logic [1:0] LEVEL_FAST   = 2'd2;

  localparam logic [2:0] RGB_RED   = 3'b100;
  localparam logic [2:0] RGB_GREEN = 3'b010;
  localparam logic [2:0] RGB_BLUE  = 3'b001;

  // Printable digit range that selects a pattern
  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_SEVEN = 8'h37;

  typedef struct packed {
    logic [1:0] opcode;
    logic [7:0] char_code;
    logic [9:0] adc_sample;
  } lps_in_t;

  typedef struct packed {
    logic [7:0]  bank_a;
    logic [7:0]  bank_b;
    logic [2:0]  pattern_now;
    logic [1:0]  speed_level;
    logic [2:0]  rgb;
    logic [15:0] reload_value;
    logic        pulse_level;
    logic        bad_entry;
  } lps_out_t;

  // Steps per pattern before the counter wraps
  function automatic logic [5:0] pat_len(input logic [2:0] pat);
    logic [5:0] len;
    case (pat)
      3'd0:    len = 6'd2;
      3'd6:    len = 6'd32;
      3'd7:    len = 6'd62;
      default: len = 6'd4;
    endcase
    return len;
  endfunction

  // Walking zero: one LED lit, active low
  function automatic logic [7:0] walk(input logic [2:0] idx);
    return ~(8'h01 << idx);
  endfunction

endpackage

// File: rtl/led_pattern_sequencer_core.sv
// LED pattern sequencer with two active-low 8-bit banks and a speed indicator.
// Input channel (in_valid/in_ready/in_data) carries one event per transfer:
// a tick, a pattern step up or down, or a received character ('0' to '7' select a pattern).
// Every accepted event yields exactly one result on the output channel
// (out_valid/out_ready/out_data) showing the state after that event.
// The state update and the result are computed in the cycle of the transfer and
// the result sits in the output register next cycle.
// Throughput is one event per cycle; the single output register limits it
// only while the receiver stalls: in_ready is low while a result waits and
// out_ready is low, and rises again in the cycle the result is taken.
// Configuration is a plain write port (cfg_we, cfg_index, cfg_wdata) for the
// two ADC thresholds and three timer reload values; unused indexes are ignored.
// Synchronous active-low reset clears pattern, step counter, banks, pulse and
// speed level, restores register defaults and empties the output register.
`include "led_pattern_sequencer_core_macros.svh"

module led_pattern_sequencer_core
  import lps_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  lps_in_t     in_data,
  output logic        out_valid,
  input  logic        out_ready,
  output lps_out_t    out_data,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_wdata
);

  logic [9:0]  thr_fast_r, thr_medium_r;
  logic [15:0] rld_slow_r, rld_medium_r, rld_fast_r;

  logic [2:0] pattern_r, pattern_nxt;
  logic [5:0] step_r, step_nxt;
  logic [7:0] bank_a_r, bank_a_nxt;
  logic [7:0] bank_b_r, bank_b_nxt;
  logic       pulse_r, pulse_nxt;
  logic [1:0] level_r, level_nxt;

  logic       out_valid_r;
  lps_out_t   out_data_r, out_data_nxt;

  logic       in_fire;
  logic [5:0] len;
  logic [5:0] cur_step;
  logic [5:0] step_inc;
  logic [2:0] sel_req;
  logic       sel_en;
  logic       bad;
  logic [7:0] show_a, show_b;
  logic [5:0] down_a, down_b;

  // Accept while the output register is empty or being drained
  assign in_ready = !out_valid_r || out_ready;
  assign in_fire  = in_valid && in_ready;

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_fast_r   <= THRESHOLD_FAST_RST;
      thr_medium_r <= THRESHOLD_MEDIUM_RST;
      rld_slow_r   <= RELOAD_SLOW_RST;
      rld_medium_r <= RELOAD_MEDIUM_RST;
      rld_fast_r   <= RELOAD_FAST_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_THRESHOLD_FAST:   thr_fast_r   <= cfg_wdata[9:0];
        REG_THRESHOLD_MEDIUM: thr_medium_r <= cfg_wdata[9:0];
        REG_RELOAD_SLOW:      rld_slow_r   <= cfg_wdata;
        REG_RELOAD_MEDIUM:    rld_medium_r <= cfg_wdata;
        REG_RELOAD_FAST:      rld_fast_r   <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Pattern display for the current step
  assign len      = pat_len(pattern_r);
  assign cur_step = (step_r >= len) ? 6'd0 : step_r;
  assign down_b   = 6'd44 - cur_step;
  assign down_a   = 6'd60 - cur_step;

  always_comb begin
    show_a = 8'hFF;
    show_b = 8'hFF;
    case (pattern_r)
      3'd0: begin
        if (cur_step == 6'd0) begin
          show_a = 8'h00;
          show_b = 8'h00;
        end
      end
      3'd1: begin
        if (cur_step < 6'd2) begin
          show_a = 8'h00;
          show_b = 8'h00;
        end
      end
      3'd2: begin
        if (cur_step == 6'd0) begin
          show_a = 8'hAA;
          show_b = 8'hAA;
        end else if (cur_step == 6'd2) begin
          show_a = 8'h55;
          show_b = 8'h55;
        end
      end
      3'd3: begin
        if (cur_step == 6'd0) show_a = 8'h00;
        else if (cur_step == 6'd2) show_b = 8'h00;
      end
      3'd4: begin
        if (cur_step == 6'd0) begin
          show_a = 8'hFC;
          show_b = 8'h03;
        end else if (cur_step == 6'd2) begin
          show_a = 8'h03;
          show_b = 8'hFC;
        end
      end
      3'd5: begin
        if (cur_step == 6'd0) begin
          show_a = 8'hF0;
          show_b = 8'hF0;
        end else if (cur_step == 6'd2) begin
          show_a = 8'h0F;
          show_b = 8'h0F;
        end
      end
      3'd6: begin
        if (!cur_step[0]) begin
          if (cur_step < 6'd16) show_a = walk(cur_step[3:1]);
          else show_b = walk(cur_step[3:1]);
        end
      end
      default: begin
        // Walk out across both banks, then back
        if (!cur_step[0]) begin
          if (cur_step < 6'd16) show_a = walk(cur_step[3:1]);
          else if (cur_step < 6'd31) show_b = walk(cur_step[3:1]);
          else if (cur_step < 6'd45) show_b = walk(down_b[3:1]);
          else if (cur_step <= 6'd61) show_a = walk(down_a[3:1]);
        end
      end
    endcase
  end

  assign step_inc = cur_step + 6'd1;

  // Event decode and next state
  always_comb begin
    pattern_nxt = pattern_r;
    step_nxt    = step_r;
    bank_a_nxt  = bank_a_r;
    bank_b_nxt  = bank_b_r;
    pulse_nxt   = pulse_r;
    level_nxt   = level_r;
    sel_req     = pattern_r;
    sel_en      = 1'b0;
    bad         = 1'b0;
    unique case (in_data.opcode)
      OP_TICK: begin
        if (in_data.adc_sample >= thr_fast_r) level_nxt = LEVEL_FAST;
        else if (in_data.adc_sample >= thr_medium_r) level_nxt = LEVEL_MEDIUM;
        else level_nxt = LEVEL_SLOW;
        pulse_nxt  = !pulse_r;
        bank_a_nxt = show_a;
        bank_b_nxt = show_b;
        step_nxt   = (step_inc >= len) ? 6'd0 : step_inc;
      end
      OP_UP: begin
        sel_req = pattern_r + 3'd1;
        sel_en  = 1'b1;
      end
      OP_DOWN: begin
        sel_req = pattern_r - 3'd1;
        sel_en  = 1'b1;
      end
      default: begin
        if (in_data.char_code >= CHAR_ZERO && in_data.char_code <= CHAR_SEVEN) begin
          sel_req = in_data.char_code[2:0];
          sel_en  = 1'b1;
        end else begin
          bad = 1'b1;
        end
      end
    endcase
    // Clear the step counter on a real pattern change
    if (sel_en && (sel_req != pattern_r)) begin
      pattern_nxt = sel_req;
      step_nxt    = 6'd0;
    end
  end

  // Assemble the result from the post-event state
  always_comb begin
    out_data_nxt.bank_a      = bank_a_nxt;
    out_data_nxt.bank_b      = bank_b_nxt;
    out_data_nxt.pattern_now = pattern_nxt;
    out_data_nxt.speed_level = level_nxt;
    out_data_nxt.pulse_level = pulse_nxt;
    out_data_nxt.bad_entry   = bad;
    unique case (level_nxt)
      LEVEL_FAST: begin
        out_data_nxt.rgb          = RGB_RED;
        out_data_nxt.reload_value = rld_fast_r;
      end
      LEVEL_MEDIUM: begin
        out_data_nxt.rgb          = RGB_GREEN;
        out_data_nxt.reload_value = rld_medium_r;
      end
      default: begin
        out_data_nxt.rgb          = RGB_BLUE;
        out_data_nxt.reload_value = rld_slow_r;
      end
    endcase
  end

  // Advance state on each input transfer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pattern_r <= '0;
      step_r    <= '0;
      bank_a_r  <= '0;
      bank_b_r  <= '0;
      pulse_r   <= 1'b0;
      level_r   <= LEVEL_SLOW;
    end else if (in_fire) begin
      pattern_r <= pattern_nxt;
      step_r    <= step_nxt;
      bank_a_r  <= bank_a_nxt;
      bank_b_r  <= bank_b_nxt;
      pulse_r   <= pulse_nxt;
      level_r   <= level_nxt;
    end
  end

  // Hold the result until the output transfer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_fire) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // A waiting result is never overwritten
  `LPS_ASSERT_NOW(a_no_overwrite, clk, rst_n, out_valid_r && !out_ready, !in_ready)
  // Step counter stays inside its pattern's length
  `LPS_ASSERT_NOW(a_step_range, clk, rst_n, 1'b1, step_r < pat_len(pattern_r))
  // Only ticks move the pulse line
  `LPS_ASSERT_NEXT(a_pulse_tick, clk, rst_n, in_fire && (in_data.opcode != OP_TICK), $stable(pulse_r))
  // Colour is one-hot and the reported level is a valid one
  `LPS_ASSERT_NOW(a_rgb_onehot, clk, rst_n, out_valid_r, $onehot(out_data_r.rgb) && (out_data_r.speed_level != 2'd3))

endmodule
